>>> rtl/acm_pkg.sv
package acm_pkg;

  localparam int unsigned SampleBitsDefault = 10;
  localparam int unsigned AxisCountDefault  = 3;
  localparam int unsigned MaxAxes           = 3;
  localparam int unsigned OutBits           = 14;
  localparam int unsigned SumBits           = 28;
  localparam int unsigned FifoDepth         = 2;

  localparam logic CmdCalibrate = 1'b0;
  localparam logic CmdMeasure   = 1'b1;

  localparam int signed ClampLimit = 8000;
  localparam int signed OutLow     = -1000;
  localparam int signed OutRange   = 2000;

  typedef struct packed {
    logic                  zero_span;
    logic                  clamped;
  } flags_t;

endpackage

>>> rtl/acm_front.sv
// Front part: holds the calibration, turns a measure item into per-axis
// differences from the stored minimum and spans for the back part.
module acm_front #(
  parameter int unsigned SampleBits = acm_pkg::SampleBitsDefault,
  parameter int unsigned AxisCount  = acm_pkg::AxisCountDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic                  command_i,
  input  logic [SampleBits-1:0] x_sample_i,
  input  logic [SampleBits-1:0] y_sample_i,
  input  logic [SampleBits-1:0] z_sample_i,
  // queue write side
  output logic                  wr_valid_o,
  input  logic                  wr_full_i,
  output logic [3*(SampleBits+1)-1:0] wr_diff_o,
  output logic [3*SampleBits-1:0]     wr_span_o
);
  import acm_pkg::*;

  localparam logic [SampleBits-1:0] Mid = SampleBits'(1) << (SampleBits - 1);

  logic [SampleBits-1:0] min_q [MaxAxes];
  logic [SampleBits-1:0] max_q [MaxAxes];
  logic [SampleBits-1:0] raw [MaxAxes];
  logic accept;

  assign raw[0] = x_sample_i;
  assign raw[1] = y_sample_i;
  assign raw[2] = z_sample_i;

  assign full_o     = wr_full_i;
  assign accept     = push_i && !wr_full_i;
  assign wr_valid_o = accept && (command_i == CmdMeasure);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxAxes; i++) begin
        min_q[i] <= Mid;
        max_q[i] <= Mid;
      end
    end else if (accept && command_i == CmdCalibrate) begin
      for (int i = 0; i < MaxAxes; i++) begin
        if (i < AxisCount) begin
          if (raw[i] < min_q[i]) min_q[i] <= raw[i];
          if (raw[i] > max_q[i]) max_q[i] <= raw[i];
        end
      end
    end
  end

  // Unused axes keep their reset range, so their span is zero; the back part
  // skips them using AxisCount.
  always_comb begin
    for (int i = 0; i < MaxAxes; i++) begin
      wr_diff_o[i*(SampleBits+1) +: SampleBits+1] =
        {1'b0, raw[i]} - {1'b0, min_q[i]};
      wr_span_o[i*SampleBits +: SampleBits] = max_q[i] - min_q[i];
    end
  end

endmodule

>>> rtl/acm_fifo.sv
module acm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = acm_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [PtrBits:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (PtrBits+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrBits'(Depth-1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == PtrBits'(Depth-1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/acm_back.sv
// Back part: up to three serial restoring divisions, one per used axis with a
// nonzero span, then a bit-pair restoring square root, then one output register.
module acm_back #(
  parameter int unsigned SampleBits = acm_pkg::SampleBitsDefault,
  parameter int unsigned AxisCount  = acm_pkg::AxisCountDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_empty_i,
  output logic                        rd_pop_o,
  input  logic [3*(SampleBits+1)-1:0] rd_diff_i,
  input  logic [3*SampleBits-1:0]     rd_span_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic signed [13:0]          x_milli_g_o,
  output logic signed [13:0]          y_milli_g_o,
  output logic signed [13:0]          z_milli_g_o,
  output logic [13:0]                 net_milli_g_o,
  output logic                        clamped_flag_o,
  output logic                        zero_span_flag_o
);
  import acm_pkg::*;

  // numerator = diff * 2000, magnitude up to 2000*2^SampleBits
  localparam int unsigned NumBits = SampleBits + 12;
  localparam int unsigned CntBits = $clog2(NumBits + 1);
  localparam int unsigned RootSteps = SumBits / 2;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StFix  = 3'd3;
  localparam logic [2:0] StSq   = 3'd4;
  localparam logic [2:0] StRoot = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]          state_q;
  logic [1:0]          axis_q;
  logic [CntBits-1:0]  cnt_q;
  logic [NumBits-1:0]  quo_q;
  logic [SampleBits:0] rem_q;
  logic                neg_q;
  logic signed [13:0]  val_q [MaxAxes];
  logic [SumBits-1:0]  sum_q, rad_q;
  logic [SumBits/2+1:0] root_q;
  logic [SumBits/2+1:0] rrem_q;
  logic [4:0]          rcnt_q;
  flags_t              flags_q;
  logic                out_valid_q;

  logic signed [SampleBits+1:0] diff_s;
  logic [SampleBits-1:0]        span;
  logic [SampleBits+1:0]        trial;
  logic signed [NumBits+1:0]    sq_val;
  logic signed [NumBits+1:0]    quo_s;
  logic [13:0]                  mag;
  logic [27:0]                  sq;
  logic [SumBits/2+1:0]         rtrial, rrem_sh;

  always_comb begin
    diff_s = $signed({{1{rd_diff_i[axis_q*(SampleBits+1) + SampleBits]}},
                      rd_diff_i[axis_q*(SampleBits+1) +: SampleBits+1]});
    span   = rd_span_i[axis_q*SampleBits +: SampleBits];
    trial  = {rem_q, quo_q[NumBits-1]} ;
    quo_s  = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    sq_val = quo_s + (NumBits+2)'(OutLow);
    mag    = val_q[axis_q][13] ? 14'(-val_q[axis_q]) : 14'(val_q[axis_q]);
    sq     = mag * mag;
    rrem_sh = {rrem_q[SumBits/2-1:0], rad_q[SumBits-1 -: 2]};
    rtrial  = {root_q[SumBits/2-1:0], 2'b01};
  end

  assign rd_pop_o = (state_q == StOut) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      axis_q      <= '0;
      cnt_q       <= '0;
      rcnt_q      <= '0;
    end else begin
      if (out_valid_q && pop_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (!rd_empty_i) begin
            axis_q  <= '0;
            flags_q <= '0;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          neg_q   <= diff_s < 0;
          quo_q   <= NumBits'((diff_s < 0 ? -diff_s : diff_s) * OutRange);
          rem_q   <= '0;
          cnt_q   <= CntBits'(NumBits);
          if (axis_q >= 2'(AxisCount)) begin
            val_q[axis_q] <= '0;
            state_q <= StFix;
          end else if (span == '0) begin
            val_q[axis_q] <= '0;
            flags_q.zero_span <= 1'b1;
            state_q <= StFix;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (trial >= {2'b00, span}) begin
            rem_q <= (SampleBits+1)'(trial - {2'b00, span});
            quo_q <= {quo_q[NumBits-2:0], 1'b1};
          end else begin
            rem_q <= trial[SampleBits:0];
            quo_q <= {quo_q[NumBits-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) state_q <= StSq;
        end
        StSq: begin
          if (sq_val > (NumBits+2)'(ClampLimit)) begin
            val_q[axis_q] <= 14'(ClampLimit);
            flags_q.clamped <= 1'b1;
          end else if (sq_val < -(NumBits+2)'(ClampLimit)) begin
            val_q[axis_q] <= -14'(ClampLimit);
            flags_q.clamped <= 1'b1;
          end else begin
            val_q[axis_q] <= 14'(sq_val);
          end
          state_q <= StFix;
        end
        StFix: begin
          if (axis_q == 2'd0) sum_q <= SumBits'(sq);
          else sum_q <= sum_q + SumBits'(sq);
          if (axis_q == 2'(MaxAxes - 1)) begin
            rad_q   <= sum_q + SumBits'(sq);
            root_q  <= '0;
            rrem_q  <= '0;
            rcnt_q  <= 5'(RootSteps);
            state_q <= StRoot;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= StLoad;
          end
        end
        StRoot: begin
          if (rrem_sh >= rtrial) begin
            rrem_q <= rrem_sh - rtrial;
            root_q <= {root_q[SumBits/2:0], 1'b1};
          end else begin
            rrem_q <= rrem_sh;
            root_q <= {root_q[SumBits/2:0], 1'b0};
          end
          rad_q  <= rad_q << 2;
          rcnt_q <= rcnt_q - 1'b1;
          if (rcnt_q == 5'd1) state_q <= StOut;
        end
        StOut: begin
          if (!out_valid_q) begin
            x_milli_g_o      <= val_q[0];
            y_milli_g_o      <= val_q[1];
            z_milli_g_o      <= val_q[2];
            net_milli_g_o    <= root_q[13:0];
            clamped_flag_o   <= flags_q.clamped;
            zero_span_flag_o <= flags_q.zero_span;
            out_valid_q      <= 1'b1;
            state_q          <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign empty_o = !out_valid_q;

endmodule

>>> rtl/accel_calibrate_and_magnitude.sv
// Three-axis accelerometer min/max calibration and milli-g conversion. A
// calibrate item widens the stored per-axis range in the front part; a
// measure item is queued and then worked through in the back part by one
// shared serial restoring divider that handles the axes in turn and a
// two-bits-per-cycle square-root unit. A queue of two measure items
// separates the calibration logic from the arithmetic, and one result
// register holds a finished result until it is popped.
module accel_calibrate_and_magnitude #(
  parameter int unsigned SAMPLE_BITS = acm_pkg::SampleBitsDefault,
  parameter int unsigned AXIS_COUNT  = acm_pkg::AxisCountDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   command_i,
  input  logic [SAMPLE_BITS-1:0] x_sample_i,
  input  logic [SAMPLE_BITS-1:0] y_sample_i,
  input  logic [SAMPLE_BITS-1:0] z_sample_i,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [13:0]     x_milli_g_o,
  output logic signed [13:0]     y_milli_g_o,
  output logic signed [13:0]     z_milli_g_o,
  output logic [13:0]            net_milli_g_o,
  output logic                   clamped_flag_o,
  output logic                   zero_span_flag_o
);
  import acm_pkg::*;

  localparam int unsigned DiffW = 3 * (SAMPLE_BITS + 1);
  localparam int unsigned SpanW = 3 * SAMPLE_BITS;

  logic             wr_valid, q_full, q_empty, q_pop;
  logic [DiffW-1:0] wr_diff, rd_diff;
  logic [SpanW-1:0] wr_span, rd_span;

  acm_front #(.SampleBits(SAMPLE_BITS), .AxisCount(AXIS_COUNT)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .command_i,
    .x_sample_i, .y_sample_i, .z_sample_i,
    .wr_valid_o(wr_valid), .wr_full_i(q_full),
    .wr_diff_o(wr_diff), .wr_span_o(wr_span)
  );

  acm_fifo #(.Width(DiffW + SpanW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(wr_valid), .full_o(q_full), .data_i({wr_diff, wr_span}),
    .pop_i(q_pop), .empty_o(q_empty), .data_o({rd_diff, rd_span})
  );

  acm_back #(.SampleBits(SAMPLE_BITS), .AxisCount(AXIS_COUNT)) u_back (
    .clk_i, .rst_ni,
    .rd_empty_i(q_empty), .rd_pop_o(q_pop),
    .rd_diff_i(rd_diff), .rd_span_i(rd_span),
    .empty_o(empty), .pop_i(pop),
    .x_milli_g_o, .y_milli_g_o, .z_milli_g_o, .net_milli_g_o,
    .clamped_flag_o, .zero_span_flag_o
  );

`ifndef SYNTH
  a_no_pop_empty_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue read while empty");
  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (net_milli_g_o <= 14'd13856)) else $error("magnitude out of range");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(net_milli_g_o)))
    else $error("result changed before transfer");
`endif

endmodule
